// File: sv/scpm_pkg.sv
package scpm_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int TOL_WIDTH   = 20;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(2500);

	// coordinate differences, magnitudes fit in COORD_WIDTH bits
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	// signed sums of two coordinate products (dot, cross, |d|^2 + dot)
	localparam int SUM_WIDTH  = 2 * COORD_WIDTH + 3;
	// multiplier operand b: magnitudes of the sums
	localparam int MB_WIDTH   = SUM_WIDTH - 1;
	// tolerance times |cross|
	localparam int TC_WIDTH   = TOL_WIDTH + 2 * COORD_WIDTH + 1;
	// product and operand a width
	localparam int MP_WIDTH   = TC_WIDTH + MB_WIDTH;

	localparam logic CMD_DRAG    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;
	localparam logic ACT_APPEND  = 1'b0;
	localparam logic ACT_MOVE    = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_WAIT = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		STEP_DOT_A,
		STEP_DOT_B,
		STEP_CRS_A,
		STEP_CRS_B,
		STEP_SUM_A,
		STEP_SUM_B,
		STEP_SQ,
		STEP_TOLC,
		STEP_LHS
	} step_t;

	typedef struct packed {
		logic                start;
		logic [MP_WIDTH-1:0] a;
		logic [MB_WIDTH-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                busy;
		logic [MP_WIDTH-1:0] prod;
	} mul_rsp_t;

endpackage

// File: sv/scpm_if.sv
interface scpm_pen_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    cmd;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] from_x;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] from_y;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] to_x;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] to_y;

	modport source (output valid, cmd, from_x, from_y, to_x, to_y, input ready);
	modport sink (input valid, cmd, from_x, from_y, to_x, to_y, output ready);
endinterface

interface scpm_vtx_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    action;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] vertex_x;
	logic signed [scpm_pkg::COORD_WIDTH-1:0] vertex_y;
	logic                                    final_of_run;

	modport source (output valid, action, vertex_x, vertex_y, final_of_run, input ready);
	modport sink (input valid, action, vertex_x, vertex_y, final_of_run, output ready);
endinterface

// File: sv/scpm_sermul.sv
module scpm_sermul (
	input  logic               clk,
	input  logic               arst_n,
	input  scpm_pkg::mul_req_t req,
	output scpm_pkg::mul_rsp_t rsp
);
	import scpm_pkg::*;

	logic [MP_WIDTH-1:0] acc_q;
	logic [MP_WIDTH-1:0] a_q;
	logic [MB_WIDTH-1:0] b_q;

	// one multiplier bit per cycle, stops as soon as the remaining bits are zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (req.start) begin
			b_q <= req.b;
		end else if (b_q != '0) begin
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
		end else if (b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
		end
	end

	assign rsp.busy = (b_q != '0);
	assign rsp.prod = acc_q;

endmodule

// File: sv/stroke_collinear_point_merger.sv
// Stroke simplifier for pen input.
// pen: one transaction per drag (cmd = drag, from/to points) or pen release.
// verts: vertex edits, append or move-last, final_of_run marks the last edit
// of a pen transaction. cfg_we/cfg_wdata load the tolerance register.
// A release is accepted from idle and yields nothing. The first drag of a
// stroke yields two appends, the first one passing through the emit state into the output register.
// A later drag runs a sequence of up to nine products on a bit-serial
// shift-and-add multiplier, one multiplier bit per cycle, each product
// taking longer the longer its second operand; the drag's edit follows
// the last product, and when the point lies behind, only the first two
// products run. The block takes a new pen transaction only in idle, once
// its edit has passed to the output register, so it takes the next
// transaction while its last edit still sits in the output register.
// A stalled receiver holds the edit in the output register; a second edit
// waits in the block until the register frees.
// Reset closes any stroke, zeroes the stored vertices, sets the tolerance
// to 2500 and empties the output register.
module stroke_collinear_point_merger (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [scpm_pkg::TOL_WIDTH-1:0]   cfg_wdata,
	scpm_pen_if.sink                         pen,
	scpm_vtx_if.source                       verts
);
	import scpm_pkg::*;

	function automatic logic [COORD_WIDTH-1:0] mag_diff(input logic [DIFF_WIDTH-1:0] v);
		logic [DIFF_WIDTH-1:0] n;
		n = v[DIFF_WIDTH-1] ? (~v + 1'b1) : v;
		return n[COORD_WIDTH-1:0];
	endfunction

	state_t state_q;
	step_t  step_q;
	step_t  step_next;
	logic   second_q;
	logic   out_valid_q;
	logic   stroke_open_q;
	logic [TOL_WIDTH-1:0]   tol_q;
	logic [COORD_WIDTH-1:0] tail_x_q, tail_y_q, before_x_q, before_y_q;

	logic [COORD_WIDTH-1:0] n_x_q, n_y_q;
	logic [DIFF_WIDTH-1:0]  dx_q, dy_q, ex_q, ey_q, gx_q, gy_q;
	logic [SUM_WIDTH-1:0]   dot_q, cross_q, s_q;
	logic [MP_WIDTH-1:0]    sq_q;
	logic [TC_WIDTH-1:0]    tc_q;
	logic                   neg_q;

	logic                   res_act_q, res_fin_q;
	logic [COORD_WIDTH-1:0] res_x_q, res_y_q;
	logic                   out_act_q, out_fin_q;
	logic [COORD_WIDTH-1:0] out_x_q, out_y_q;

	mul_req_t req;
	mul_rsp_t rsp;

	logic                   accept;
	logic [DIFF_WIDTH-1:0]  dx_n, dy_n, ex_n, ey_n, gx_n, gy_n;
	logic [MB_WIDTH-1:0]    cross_mag;
	logic                   neg_c;
	logic [SUM_WIDTH-1:0]   pmag, term;
	logic                   dot_nonpos, early_append, lhs_done, decide, move, emit_now;

	scpm_sermul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign accept = pen.valid && pen.ready;
	assign pen.ready = (state_q == S_IDLE);

	assign dx_n = {tail_x_q[COORD_WIDTH-1], tail_x_q} - {before_x_q[COORD_WIDTH-1], before_x_q};
	assign dy_n = {tail_y_q[COORD_WIDTH-1], tail_y_q} - {before_y_q[COORD_WIDTH-1], before_y_q};
	assign ex_n = {pen.to_x[COORD_WIDTH-1], pen.to_x} - {tail_x_q[COORD_WIDTH-1], tail_x_q};
	assign ey_n = {pen.to_y[COORD_WIDTH-1], pen.to_y} - {tail_y_q[COORD_WIDTH-1], tail_y_q};
	// N - B = d + e, so d.(N - B) = |d|^2 + dot
	assign gx_n = {pen.to_x[COORD_WIDTH-1], pen.to_x} - {before_x_q[COORD_WIDTH-1], before_x_q};
	assign gy_n = {pen.to_y[COORD_WIDTH-1], pen.to_y} - {before_y_q[COORD_WIDTH-1], before_y_q};

	assign cross_mag = cross_q[SUM_WIDTH-1] ? MB_WIDTH'(~cross_q + 1'b1) : MB_WIDTH'(cross_q);

	assign dot_nonpos   = dot_q[SUM_WIDTH-1] || (dot_q == '0);
	assign early_append = (state_q == S_LOAD) && (step_q == STEP_CRS_A) && dot_nonpos;
	assign lhs_done     = (state_q == S_WAIT) && !rsp.busy && (step_q == STEP_LHS);
	assign decide       = early_append || lhs_done;
	assign move         = lhs_done && (rsp.prod < sq_q);
	assign emit_now     = (state_q == S_EMIT) && (!out_valid_q || verts.ready);

	// operand select for the current step
	always_comb begin
		req.start = (state_q == S_LOAD) && !early_append;
		req.a     = '0;
		req.b     = '0;
		neg_c     = 1'b0;
		case (step_q)
			STEP_DOT_A: begin
				req.a = MP_WIDTH'(mag_diff(dx_q));
				req.b = MB_WIDTH'(mag_diff(ex_q));
				neg_c = dx_q[DIFF_WIDTH-1] ^ ex_q[DIFF_WIDTH-1];
			end
			STEP_DOT_B: begin
				req.a = MP_WIDTH'(mag_diff(dy_q));
				req.b = MB_WIDTH'(mag_diff(ey_q));
				neg_c = dy_q[DIFF_WIDTH-1] ^ ey_q[DIFF_WIDTH-1];
			end
			STEP_CRS_A: begin
				req.a = MP_WIDTH'(mag_diff(dx_q));
				req.b = MB_WIDTH'(mag_diff(ey_q));
				neg_c = dx_q[DIFF_WIDTH-1] ^ ey_q[DIFF_WIDTH-1];
			end
			STEP_CRS_B: begin
				// subtracted term
				req.a = MP_WIDTH'(mag_diff(dy_q));
				req.b = MB_WIDTH'(mag_diff(ex_q));
				neg_c = ~(dy_q[DIFF_WIDTH-1] ^ ex_q[DIFF_WIDTH-1]);
			end
			STEP_SUM_A: begin
				req.a = MP_WIDTH'(mag_diff(dx_q));
				req.b = MB_WIDTH'(mag_diff(gx_q));
				neg_c = dx_q[DIFF_WIDTH-1] ^ gx_q[DIFF_WIDTH-1];
			end
			STEP_SUM_B: begin
				req.a = MP_WIDTH'(mag_diff(dy_q));
				req.b = MB_WIDTH'(mag_diff(gy_q));
				neg_c = dy_q[DIFF_WIDTH-1] ^ gy_q[DIFF_WIDTH-1];
			end
			STEP_SQ: begin
				// sum is positive here, dot > 0
				req.a = MP_WIDTH'(s_q[MB_WIDTH-1:0]);
				req.b = s_q[MB_WIDTH-1:0];
			end
			STEP_TOLC: begin
				req.a = MP_WIDTH'(tol_q);
				req.b = cross_mag;
			end
			STEP_LHS: begin
				req.a = MP_WIDTH'(tc_q);
				req.b = cross_mag;
			end
			default: begin
				req.a = '0;
			end
		endcase
	end

	always_comb begin
		case (step_q)
			STEP_DOT_A: step_next = STEP_DOT_B;
			STEP_DOT_B: step_next = STEP_CRS_A;
			STEP_CRS_A: step_next = STEP_CRS_B;
			STEP_CRS_B: step_next = STEP_SUM_A;
			STEP_SUM_A: step_next = STEP_SUM_B;
			STEP_SUM_B: step_next = STEP_SQ;
			STEP_SQ:    step_next = STEP_TOLC;
			STEP_TOLC:  step_next = STEP_LHS;
			default:    step_next = STEP_DOT_A;
		endcase
	end

	assign pmag = rsp.prod[SUM_WIDTH-1:0];
	assign term = neg_q ? (~pmag + 1'b1) : pmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= STEP_DOT_A;
			second_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			stroke_open_q <= 1'b0;
			tol_q         <= TOL_RESET;
			tail_x_q      <= '0;
			tail_y_q      <= '0;
			before_x_q    <= '0;
			before_y_q    <= '0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (accept) begin
				if (pen.cmd == CMD_RELEASE) begin
					stroke_open_q <= 1'b0;
				end else if (!stroke_open_q) begin
					before_x_q    <= pen.from_x;
					before_y_q    <= pen.from_y;
					tail_x_q      <= pen.to_x;
					tail_y_q      <= pen.to_y;
					stroke_open_q <= 1'b1;
					second_q      <= 1'b1;
					state_q       <= S_EMIT;
				end else begin
					step_q  <= STEP_DOT_A;
					state_q <= S_LOAD;
				end
			end
			if (state_q == S_LOAD && !early_append) begin
				state_q <= S_WAIT;
			end
			if (state_q == S_WAIT && !rsp.busy && step_q != STEP_LHS) begin
				step_q  <= step_next;
				state_q <= S_LOAD;
			end
			if (decide) begin
				tail_x_q <= n_x_q;
				tail_y_q <= n_y_q;
				if (!move) begin
					before_x_q <= tail_x_q;
					before_y_q <= tail_y_q;
				end
				state_q <= S_EMIT;
			end
			if (emit_now) begin
				if (second_q) begin
					second_q <= 1'b0;
				end else begin
					state_q <= S_IDLE;
				end
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (verts.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_x_q     <= pen.to_x;
			n_y_q     <= pen.to_y;
			dx_q      <= dx_n;
			dy_q      <= dy_n;
			ex_q      <= ex_n;
			ey_q      <= ey_n;
			gx_q      <= gx_n;
			gy_q      <= gy_n;
			dot_q     <= '0;
			cross_q   <= '0;
			s_q       <= '0;
			res_act_q <= ACT_APPEND;
			res_x_q   <= pen.from_x;
			res_y_q   <= pen.from_y;
			res_fin_q <= 1'b0;
		end
		if (state_q == S_LOAD) begin
			neg_q <= neg_c;
		end
		if (state_q == S_WAIT && !rsp.busy) begin
			case (step_q)
				STEP_DOT_A, STEP_DOT_B: dot_q   <= dot_q + term;
				STEP_CRS_A, STEP_CRS_B: cross_q <= cross_q + term;
				STEP_SUM_A, STEP_SUM_B: s_q     <= s_q + term;
				STEP_SQ:                sq_q    <= rsp.prod;
				STEP_TOLC:              tc_q    <= rsp.prod[TC_WIDTH-1:0];
				default:                tc_q    <= tc_q;
			endcase
		end
		if (decide) begin
			res_act_q <= move ? ACT_MOVE : ACT_APPEND;
			res_x_q   <= n_x_q;
			res_y_q   <= n_y_q;
			res_fin_q <= 1'b1;
		end
		if (emit_now) begin
			out_act_q <= res_act_q;
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_fin_q <= res_fin_q;
			if (second_q) begin
				res_act_q <= ACT_APPEND;
				res_x_q   <= n_x_q;
				res_y_q   <= n_y_q;
				res_fin_q <= 1'b1;
			end
		end
	end

	assign verts.valid        = out_valid_q;
	assign verts.action       = out_act_q;
	assign verts.vertex_x     = out_x_q;
	assign verts.vertex_y     = out_y_q;
	assign verts.final_of_run = out_fin_q;

	a_start_idle_mul : assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rsp.busy)
		else $error("multiplier restarted while busy");

	a_move_is_final : assert property (@(posedge clk) disable iff (!arst_n)
		(verts.valid && verts.action == ACT_MOVE) |-> verts.final_of_run)
		else $error("move edit without final_of_run");

	a_second_in_emit : assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (state_q == S_EMIT))
		else $error("pending second edit outside emit state");

	a_partial_open : assert property (@(posedge clk) disable iff (!arst_n)
		(verts.valid && !verts.final_of_run) |-> stroke_open_q)
		else $error("first vertex of a stroke shown with no stroke open");

endmodule
